// ===== hw/rtl/oate_pkg.sv =====
// Shared types, operation codes and result codes for the ordered array table engine.
package oate_pkg;

  localparam int POS_W = 4;
  localparam int CFG_W = 5;

  typedef logic [2:0]         mode_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic signed [31:0] word_t;
  typedef logic [1:0]         status_t;
  typedef logic [CFG_W-1:0]   cfg_t;

  // Operation codes carried in the mode field.
  localparam mode_t MODE_INSERT  = 3'd0;
  localparam mode_t MODE_DELETE  = 3'd1;
  localparam mode_t MODE_APPEND  = 3'd2;
  localparam mode_t MODE_LSEARCH = 3'd3;
  localparam mode_t MODE_BSEARCH = 3'd4;

  // Result status codes.
  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_REJECT   = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;

  // Reset value of the capacity register.
  localparam cfg_t CFG_RESET = 5'd16;

  // One input item.
  typedef struct packed {
    mode_t mode;
    pos_t  position;
    word_t operand_value;
  } item_t;

  // One result item.
  typedef struct packed {
    status_t status;
    pos_t    found_index;
    word_t   removed_value;
  } result_t;

endpackage

// ===== hw/rtl/oate_if.sv =====
// Channel interfaces for the input, result and configuration beats.
interface oate_in_if import oate_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_t mode;
  pos_t  position;
  word_t operand_value;

  modport source (output valid, mode, position, operand_value, input ready);
  modport sink (input valid, mode, position, operand_value, output ready);
endinterface

interface oate_out_if import oate_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  pos_t    found_index;
  word_t   removed_value;

  modport source (output valid, status, found_index, removed_value, input ready);
  modport sink (input valid, status, found_index, removed_value, output ready);
endinterface

interface oate_cfg_if import oate_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/oate_table.sv =====
// Entry storage: one write port and one read port with registered read data.
module oate_table import oate_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  word_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output word_t         rdata
);

  word_t mem [DEPTH];
  word_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/oate_seq.sv =====
// Operation sequencer: walks the entry memory for shifts and searches.
module oate_seq import oate_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  input  item_t         item,
  output logic          item_ready,
  input  cfg_t          cap_cfg,
  output logic          res_valid,
  output result_t       res,
  input  logic          res_ready,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output word_t         mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  word_t         mem_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS     = 4'd1;
  localparam logic [3:0] S_DEL     = 4'd2;
  localparam logic [3:0] S_LIN     = 4'd3;
  localparam logic [3:0] S_SWAP_A  = 4'd4;
  localparam logic [3:0] S_SWAP_B  = 4'd5;
  localparam logic [3:0] S_BIN_RD  = 4'd6;
  localparam logic [3:0] S_BIN_CMP = 4'd7;
  localparam logic [3:0] S_RESP    = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hip1_r, hip1_nxt;
  logic [AW-1:0] mid_r, mid_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  word_t         key_r, key_nxt;
  word_t         e0_r, e0_nxt;
  status_t       status_r, status_nxt;
  logic [AW-1:0] found_r, found_nxt;
  word_t         removed_r, removed_nxt;

  logic [PW-1:0] pos_ext;
  logic          room;
  logic          ins_ok;
  logic          del_ok;
  logic [CW-1:0] ptr_m1;
  logic [CW:0]   mid_sum;
  logic [AW+3:0] found_ext;

  // Admission checks against the fill count and the capacity limit.
  assign pos_ext = PW'(item.position);
  assign room    = (LW'(fill_r) < LW'(cap_cfg)) && (fill_r < CAP_C);
  assign ins_ok  = (pos_ext <= PW'(fill_r)) && room;
  assign del_ok  = pos_ext < PW'(fill_r);
  assign ptr_m1  = ptr_r - 1'b1;
  // Binary search midpoint: (lo + hi) / 2 with hi = hip1 - 1.
  assign mid_sum = (CW+1)'(lo_r) + (CW+1)'(hip1_r) - 1'b1;

  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_RESP);

  assign found_ext         = {4'b0000, found_r};
  assign res.status        = status_r;
  assign res.found_index   = found_ext[3:0];
  assign res.removed_value = removed_r;

  // Next-state and memory access logic.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    hip1_nxt      = hip1_r;
    mid_nxt       = mid_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    key_nxt       = key_r;
    e0_nxt        = e0_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    removed_nxt   = removed_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          key_nxt     = item.operand_value;
          found_nxt   = '0;
          removed_nxt = '0;
          status_nxt  = ST_REJECT;
          pend_nxt    = 1'b0;
          state_nxt   = S_RESP;
          unique case (item.mode)
            MODE_INSERT: begin
              if (ins_ok) begin
                ptr_nxt   = fill_r;
                pos_nxt   = pos_ext[CW-1:0];
                state_nxt = S_INS;
              end
            end
            MODE_DELETE: begin
              if (del_ok) begin
                ptr_nxt   = pos_ext[CW-1:0];
                pos_nxt   = pos_ext[CW-1:0];
                state_nxt = S_DEL;
              end
            end
            MODE_APPEND: begin
              if (room) begin
                mem_we     = 1'b1;
                mem_waddr  = fill_r[AW-1:0];
                mem_wdata  = item.operand_value;
                fill_nxt   = fill_r + 1'b1;
                status_nxt = ST_DONE;
              end
            end
            MODE_LSEARCH: begin
              ptr_nxt    = '0;
              status_nxt = ST_NOTFOUND;
              state_nxt  = S_LIN;
            end
            MODE_BSEARCH: begin
              lo_nxt     = '0;
              hip1_nxt   = fill_r;
              status_nxt = ST_NOTFOUND;
              state_nxt  = S_BIN_RD;
            end
            default: begin
            end
          endcase
        end
      end

      // Shift up: read downward from the top, write each word one place higher.
      S_INS: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r + 1'b1;
          mem_wdata = mem_rdata;
        end
        if (ptr_r > pos_r) begin
          mem_re        = 1'b1;
          mem_raddr     = ptr_m1[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_m1[AW-1:0];
          ptr_nxt       = ptr_m1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            mem_we     = 1'b1;
            mem_waddr  = pos_r[AW-1:0];
            mem_wdata  = key_r;
            fill_nxt   = fill_r + 1'b1;
            status_nxt = ST_DONE;
            state_nxt  = S_RESP;
          end
        end
      end

      // Shift down: the first word read is the removed one, the rest move one lower.
      S_DEL: begin
        if (pend_r) begin
          if (pend_addr_r == pos_r[AW-1:0]) begin
            removed_nxt = mem_rdata;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_r - 1'b1;
            mem_wdata = mem_rdata;
          end
        end
        if (ptr_r < fill_r) begin
          mem_re        = 1'b1;
          mem_raddr     = ptr_r[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[AW-1:0];
          ptr_nxt       = ptr_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            fill_nxt   = fill_r - 1'b1;
            status_nxt = ST_DONE;
            state_nxt  = S_RESP;
          end
        end
      end

      // Linear scan from entry 0; entry 0 is kept for the swap.
      S_LIN: begin
        if (pend_r && (pend_addr_r == '0)) begin
          e0_nxt = mem_rdata;
        end
        if (pend_r && (mem_rdata == key_r)) begin
          found_nxt  = pend_addr_r;
          status_nxt = ST_DONE;
          pend_nxt   = 1'b0;
          state_nxt  = S_SWAP_A;
        end else if (ptr_r < fill_r) begin
          mem_re        = 1'b1;
          mem_raddr     = ptr_r[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[AW-1:0];
          ptr_nxt       = ptr_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_RESP;
          end
        end
      end

      // Move to head: old head goes to the hit slot, the key goes to the head.
      S_SWAP_A: begin
        mem_we    = 1'b1;
        mem_waddr = found_r;
        mem_wdata = e0_r;
        state_nxt = S_SWAP_B;
      end

      S_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = key_r;
        state_nxt = S_RESP;
      end

      // Binary search: read the midpoint, then narrow the range.
      S_BIN_RD: begin
        if (lo_r < hip1_r) begin
          mem_re    = 1'b1;
          mem_raddr = mid_sum[AW:1];
          mid_nxt   = mid_sum[AW:1];
          state_nxt = S_BIN_CMP;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_BIN_CMP: begin
        if (mem_rdata == key_r) begin
          found_nxt  = mid_r;
          status_nxt = ST_DONE;
          state_nxt  = S_RESP;
        end else begin
          if (key_r < mem_rdata) begin
            hip1_nxt = CW'(mid_r);
          end else begin
            lo_nxt = CW'(mid_r) + 1'b1;
          end
          state_nxt = S_BIN_RD;
        end
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    pos_r       <= pos_nxt;
    lo_r        <= lo_nxt;
    hip1_r      <= hip1_nxt;
    mid_r       <= mid_nxt;
    pend_addr_r <= pend_addr_nxt;
    key_r       <= key_nxt;
    e0_r        <= e0_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    removed_r   <= removed_nxt;
  end

endmodule

// ===== hw/rtl/ordered_array_table_engine.sv =====
// Top level of the ordered array table engine: channels, capacity register, result register.
// The engine keeps up to CAPACITY signed 32-bit words in one single-port-read memory and
// runs one operation per input beat: insert, delete, append, linear search with move to
// head, or binary search. Items are taken one at a time; the input is ready only while the
// sequencer is idle. Every operation moves at most one memory read and one write per
// cycle, so its length follows the number of entries it touches, and that of a binary
// search follows the number of halving steps. A finished result sits in an output
// register, so the next beat can be accepted while it waits to be taken. The capacity
// register may be written only while the engine is idle; the memory needs no clearing
// after reset, since only entries below the fill count are ever read.
module ordered_array_table_engine import oate_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  oate_in_if.sink    in_bus,
  oate_out_if.source out_bus,
  oate_cfg_if.sink   cfg_bus
);

  localparam int AW = $clog2(CAPACITY);

  cfg_t          cap_r;
  logic          out_valid_r;
  result_t       out_data_r;
  logic          out_free;
  logic          res_valid;
  result_t       res;
  item_t         item;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  word_t         mem_rdata;

  // Capacity register, always ready for a write beat.
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CFG_RESET;
    end else if (cfg_bus.valid) begin
      cap_r <= cfg_bus.data;
    end
  end

  assign item.mode          = in_bus.mode;
  assign item.position      = in_bus.position;
  assign item.operand_value = in_bus.operand_value;

  oate_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_bus.valid),
    .item       (item),
    .item_ready (in_bus.ready),
    .cap_cfg    (cap_r),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (out_free),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  oate_table #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: loads a result when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.status        = out_data_r.status;
  assign out_bus.found_index   = out_data_r.found_index;
  assign out_bus.removed_value = out_data_r.removed_value;

endmodule
